// ----- hdl/spqd_pkg.sv -----
// Package for the stable priority queue with duplicate rejection.
// Holds default sizes, result status codes, level bounds and the
// control and flag structs shared by the top level and the compare unit.
package spqd_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 64;
    localparam int TAG_BITS_DEF    = 32;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    localparam logic [2:0] LEVEL_MOST  = 3'd1;
    localparam logic [2:0] LEVEL_LEAST = 3'd3;

    typedef struct packed {
        logic clear;
        logic enable;
    } t_cmp_ctrl;

    typedef struct packed {
        logic dup;
        logic found;
    } t_cmp_flags;

endpackage

// ----- hdl/spqd_ram.sv -----
// Entry store of the queue: one write port and one registered read port.
// Depends on nothing; the top level sets depth and entry width.
module spqd_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 98
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/spqd_cmp.sv -----
// Compare unit for the insert scan: checks each scanned entry for an equal key and finds
// the first entry of a less urgent level. Depends on spqd_pkg for its structs.
module spqd_cmp #(
    parameter int KEY_BITS = 64,
    parameter int CW       = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  spqd_pkg::t_cmp_ctrl    i_ctrl,
    input  logic [CW-1:0]          i_idx,
    input  logic [KEY_BITS-1:0]    i_ent_key,
    input  logic [1:0]             i_ent_level,
    input  logic [KEY_BITS-1:0]    i_new_key,
    input  logic [1:0]             i_new_level,
    output spqd_pkg::t_cmp_flags   o_flags,
    output logic [CW-1:0]          o_pos
);

    spqd_pkg::t_cmp_flags r_flags;
    logic [CW-1:0]        r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_flags <= '0;
        end else if (i_ctrl.enable) begin
            if (i_ent_key == i_new_key) begin
                r_flags.dup <= 1'b1;
            end
            if (!r_flags.found && (i_ent_level > i_new_level)) begin
                r_flags.found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.enable && !r_flags.found && (i_ent_level > i_new_level)) begin
            r_pos <= i_idx;
        end
    end

    assign o_flags = r_flags;
    assign o_pos   = r_pos;

endmodule

// ----- hdl/stable_priority_queue_dedup_core.sv -----
// Top level of the stable three-level priority queue with duplicate rejection.
// Holds the sequencer and the ring pointers; uses spqd_pkg, spqd_ram and spqd_cmp.
//
// Channel  Direction  Handshake                   Payload
// input    in         i_in_valid / o_in_ready     i_cmd, i_entry_key, i_entry_priority,
//                                                 i_entry_tag
// result   out        o_out_valid / i_out_ready   o_status, o_out_key, o_out_priority,
//                                                 o_out_tag, o_occupancy
//
// An insert scans the held entries, then moves the entries behind its slot P back by one
// place and stores itself at P, then gives its result. A pop reads the head entry and
// gives its result; on an empty queue it gives the result without a read.
// Reset clears the state, the count, the head pointer and the output valid; the entry store needs no clearing.
// One item is in work at a time; a result waits in the output register after its
// transfer, and the next item may run but holds its result until that register frees.
module stable_priority_queue_dedup_core #(
    parameter int QUEUE_DEPTH = spqd_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_BITS    = spqd_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS    = spqd_pkg::TAG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [63:0] i_entry_key,
    input  logic [2:0]  i_entry_priority,
    input  logic [31:0] i_entry_tag,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_out_key,
    output logic [1:0]  o_out_priority,
    output logic [31:0] o_out_tag,
    output logic [6:0]  o_occupancy
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int OW = (CW > 7) ? CW : 7;
    localparam int EW = 2 + KEY_BITS + TAG_BITS;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_POP   = 5'b01000,
        S_RES   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pidx, n_pidx;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_pv, n_pv;
    logic [1:0]    r_res, n_res;
    logic          r_is_pop;

    logic [KEY_BITS-1:0] r_key;
    logic [1:0]          r_level;
    logic [TAG_BITS-1:0] r_tag;

    logic          r_o_valid;
    logic [1:0]    r_o_status;
    logic [63:0]   r_o_key;
    logic [1:0]    r_o_prio;
    logic [31:0]   r_o_tag;
    logic [6:0]    r_o_occ;

    logic          w_accept;
    logic          w_out_free;
    logic          w_re, w_we;
    logic [CW-1:0] w_rlidx, w_wlidx;
    logic [AW-1:0] w_raddr, w_waddr;
    logic [EW-1:0] w_wdata, w_rdata;
    logic [1:0]    w_new_level;
    logic [63:0]   w_tag_in;
    logic [63:0]   w_key_out;
    logic [63:0]   w_tag_out;
    logic [OW-1:0] w_occ;

    spqd_pkg::t_cmp_ctrl  w_cmp_ctrl;
    spqd_pkg::t_cmp_flags w_cmp_flags;
    logic [CW-1:0]        w_cmp_pos;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] lidx);
        logic [SW-1:0] sum;
        begin
            sum = SW'(head) + SW'(lidx);
            if (sum >= SW'(QUEUE_DEPTH)) begin
                sum = sum - SW'(QUEUE_DEPTH);
            end
            return sum[AW-1:0];
        end
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_o_valid || i_out_ready;

    assign w_new_level = ((i_entry_priority >= spqd_pkg::LEVEL_MOST) &&
                          (i_entry_priority <= spqd_pkg::LEVEL_LEAST)) ?
                         i_entry_priority[1:0] : spqd_pkg::LEVEL_LEAST[1:0];
    assign w_tag_in    = {32'd0, i_entry_tag};

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_head  = r_head;
        n_idx   = r_idx;
        n_pidx  = r_pidx;
        n_pos   = r_pos;
        n_pv    = 1'b0;
        n_res   = r_res;
        w_re    = 1'b0;
        w_we    = 1'b0;
        w_rlidx = r_idx;
        w_wlidx = r_pidx;
        w_wdata = w_rdata;
        w_cmp_ctrl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_cmp_ctrl.clear = 1'b1;
                    n_idx = '0;
                    if (i_cmd == spqd_pkg::CMD_POP) begin
                        if (r_count == '0) begin
                            n_res   = spqd_pkg::ST_EMPTY;
                            n_state = S_RES;
                        end else begin
                            n_state = S_POP;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                w_cmp_ctrl.enable = r_pv;
                w_rlidx = r_idx;
                if (r_idx < r_count) begin
                    w_re   = 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + 1'b1;
                end else if (!r_pv) begin
                    if (w_cmp_flags.dup) begin
                        n_res   = spqd_pkg::ST_DUP;
                        n_state = S_RES;
                    end else if (r_count == CW'(QUEUE_DEPTH)) begin
                        n_res   = spqd_pkg::ST_FULL;
                        n_state = S_RES;
                    end else begin
                        n_pos   = w_cmp_flags.found ? w_cmp_pos : r_count;
                        n_idx   = r_count;
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                w_rlidx = r_idx - 1'b1;
                if (r_pv) begin
                    w_we    = 1'b1;
                    w_wlidx = r_pidx;
                    w_wdata = w_rdata;
                end
                if (r_idx > r_pos) begin
                    w_re   = 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx - 1'b1;
                end else if (!r_pv) begin
                    w_we    = 1'b1;
                    w_wlidx = r_pos;
                    w_wdata = {r_level, r_key, r_tag};
                    n_count = r_count + 1'b1;
                    n_res   = spqd_pkg::ST_OK;
                    n_state = S_RES;
                end
            end
            S_POP: begin
                w_re    = 1'b1;
                w_rlidx = '0;
                n_count = r_count - 1'b1;
                n_head  = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_res   = spqd_pkg::ST_OK;
                n_state = S_RES;
            end
            S_RES: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_raddr = f_phys(r_head, w_rlidx);
    assign w_waddr = f_phys(r_head, w_wlidx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_pos  <= n_pos;
        r_res  <= n_res;
        if (w_accept) begin
            r_is_pop <= i_cmd;
            r_key    <= i_entry_key[KEY_BITS-1:0];
            r_level  <= w_new_level;
            r_tag    <= w_tag_in[TAG_BITS-1:0];
        end
    end

    assign w_key_out = 64'(w_rdata[TAG_BITS +: KEY_BITS]);
    assign w_tag_out = 64'(w_rdata[TAG_BITS-1:0]);
    assign w_occ     = OW'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == S_RES) && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RES) && w_out_free) begin
            r_o_status <= r_res;
            r_o_occ    <= w_occ[6:0];
            if (r_is_pop && (r_res == spqd_pkg::ST_OK)) begin
                r_o_key  <= w_key_out;
                r_o_prio <= w_rdata[EW-1 -: 2];
                r_o_tag  <= w_tag_out[31:0];
            end else begin
                r_o_key  <= '0;
                r_o_prio <= '0;
                r_o_tag  <= '0;
            end
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_out_key      = r_o_key;
    assign o_out_priority = r_o_prio;
    assign o_out_tag      = r_o_tag;
    assign o_occupancy    = r_o_occ;

    spqd_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    spqd_cmp #(
        .KEY_BITS (KEY_BITS),
        .CW       (CW)
    ) u_cmp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_cmp_ctrl),
        .i_idx       (r_pidx),
        .i_ent_key   (w_rdata[TAG_BITS +: KEY_BITS]),
        .i_ent_level (w_rdata[EW-1 -: 2]),
        .i_new_key   (r_key),
        .i_new_level (r_level),
        .o_flags     (w_cmp_flags),
        .o_pos       (w_cmp_pos)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_shift_above_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SHIFT) && r_pv) |-> (r_pidx > r_pos))
        else $error("A moved entry lands at or before the insertion slot.");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == spqd_pkg::CMD_POP) && (r_count != '0))
        |-> ##2 (r_count == CW'($past(r_count, 2) - 1'b1)))
        else $error("A pop of a filled queue did not lower the count by one.");

endmodule
